/* rtl/lus_pkg.sv */
`default_nettype none
package lus_pkg;

	localparam int MAX_WIDTH_DEF = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int QDEPTH = 2;
	localparam int CFG_IW = 8;
	localparam int CFG_DW = 9;
	localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH = 8'd0;
	localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 8'd1;
	localparam logic [CFG_DW-1:0] FRAME_DIM_RESET = 9'd256;
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [9:0] pos_x;
		logic [9:0] pos_y;
		logic [7:0] pixel_in;
	} item_t;

	typedef struct packed {
		logic [7:0] sample;
		logic out_of_range;
	} result_t;

	typedef enum logic [1:0] {
		K_WRITE,
		K_READ,
		K_OOR
	} kind_t;

	typedef struct packed {
		kind_t kind;
		item_t item;
	} qent_t;

endpackage
`default_nettype wire

/* rtl/lus_ram.sv */
`default_nettype none
module lus_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

/* rtl/lus_front.sv */
`default_nettype none
module lus_front #(
	parameter int MAX_WIDTH = lus_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lus_pkg::MAX_HEIGHT_DEF
) (
	input wire logic start,
	input wire lus_pkg::item_t item,
	input wire logic [$clog2(MAX_WIDTH+1)-1:0] eff_w,
	input wire logic [$clog2(MAX_HEIGHT+1)-1:0] eff_h,
	input wire logic q_full,
	output logic busy,
	output logic push,
	output lus_pkg::qent_t push_ent
);

	localparam int EW = $clog2(MAX_WIDTH+1);
	localparam int EH = $clog2(MAX_HEIGHT+1);
	localparam int EM = (EW > EH) ? EW : EH;
	localparam int LW = (EM + 3 > 11) ? EM + 3 : 11;

	logic [LW-1:0] px;
	logic [LW-1:0] py;
	logic [LW-1:0] lim_x;
	logic [LW-1:0] lim_y;
	logic in_store;
	logic beyond;

	assign busy = q_full;

	always_comb begin
		px = LW'(item.pos_x);
		py = LW'(item.pos_y);
		lim_x = (LW'(eff_w) << 2) - LW'(4);
		lim_y = (LW'(eff_h) << 2) - LW'(4);
		in_store = (px < LW'(MAX_WIDTH)) && (py < LW'(MAX_HEIGHT));
		beyond = (px > lim_x) || (py > lim_y);
		push_ent.item = item;
		if (item.cmd == lus_pkg::CMD_WRITE) begin
			push_ent.kind = lus_pkg::K_WRITE;
			push = start && !q_full && in_store;
		end else begin
			push_ent.kind = beyond ? lus_pkg::K_OOR : lus_pkg::K_READ;
			push = start && !q_full;
		end
	end

endmodule
`default_nettype wire

/* rtl/lus_queue.sv */
`default_nettype none
module lus_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire lus_pkg::qent_t push_ent,
	input wire logic pop,
	output logic full,
	output logic head_valid,
	output lus_pkg::qent_t head
);

	localparam int PW = $clog2(lus_pkg::QDEPTH);
	localparam int CW = $clog2(lus_pkg::QDEPTH + 1);

	lus_pkg::qent_t mem_q [lus_pkg::QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CW'(lus_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(lus_pkg::QDEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(lus_pkg::QDEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule
`default_nettype wire

/* rtl/lus_back.sv */
`default_nettype none
module lus_back #(
	parameter int MAX_WIDTH = lus_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lus_pkg::MAX_HEIGHT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [$clog2(MAX_WIDTH+1)-1:0] eff_w,
	input wire logic [$clog2(MAX_HEIGHT+1)-1:0] eff_h,
	input wire logic head_valid,
	input wire lus_pkg::qent_t head,
	output logic pop,
	output logic done,
	output lus_pkg::result_t result
);

	localparam int CB = $clog2(MAX_WIDTH);
	localparam int RB = $clog2(MAX_HEIGHT);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int BM = (CB > RB) ? CB : RB;
	localparam int SW = ((BM > 8) ? BM : 8) + 3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_LAST,
		S_C1,
		S_C2,
		S_C3
	} state_t;

	state_t state_q;
	logic [7:0] r_q;
	logic [7:0] c_q;
	logic [1:0] fy_q;
	logic [1:0] fx_q;
	logic [2:0] ri_q;
	logic [2:0] ci_q;
	logic rd_pend_q;
	logic done_q;
	lus_pkg::result_t result_q;
	logic [7:0] win_q [36];
	logic signed [15:0] hs_s1 [6];
	logic signed [15:0] vs0_s1;
	logic signed [15:0] vs1_s1;
	logic [7:0] g00_s1;
	logic [7:0] g01_s1;
	logic [7:0] g10_s1;
	logic [7:0] b_s2;
	logic [7:0] s_s2;
	logic [7:0] h_s2;
	logic [7:0] m_s2;
	logic [7:0] j_s2;

	logic signed [SW-1:0] tr;
	logic signed [SW-1:0] tc;
	logic signed [SW-1:0] hmax;
	logic signed [SW-1:0] wmax;
	logic [RB-1:0] rd_row;
	logic [CB-1:0] rd_col;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0] ram_rdata;
	logic [7:0] pick;

	function automatic logic signed [21:0] tap6(input logic signed [21:0] a, input logic signed [21:0] b,
			input logic signed [21:0] c, input logic signed [21:0] d,
			input logic signed [21:0] e, input logic signed [21:0] f);
		tap6 = a + f - 22'sd5 * (b + e) + 22'sd20 * (c + d);
	endfunction

	function automatic logic signed [21:0] px22(input logic [7:0] p);
		px22 = $signed({14'd0, p});
	endfunction

	function automatic logic [7:0] sat(input logic signed [21:0] t);
		if (t < 0) begin
			sat = 8'd0;
		end else if (t > 22'sd255) begin
			sat = 8'd255;
		end else begin
			sat = t[7:0];
		end
	endfunction

	function automatic logic [7:0] avg(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b} + 9'd1;
		avg = s[8:1];
	endfunction

	assign pop = (state_q == S_IDLE) && head_valid;
	assign ram_we = pop && (head.kind == lus_pkg::K_WRITE);
	assign done = done_q;
	assign result = result_q;

	always_comb begin
		hmax = SW'(eff_h) - SW'(1);
		wmax = SW'(eff_w) - SW'(1);
		tr = SW'(r_q) + SW'(ri_q) - SW'(2);
		tc = SW'(c_q) + SW'(ci_q) - SW'(2);
		if (tr < 0) begin
			rd_row = '0;
		end else if (tr > hmax) begin
			rd_row = hmax[RB-1:0];
		end else begin
			rd_row = tr[RB-1:0];
		end
		if (tc < 0) begin
			rd_col = '0;
		end else if (tc > wmax) begin
			rd_col = wmax[CB-1:0];
		end else begin
			rd_col = tc[CB-1:0];
		end
		rd_addr = AW'(rd_row) * AW'(MAX_WIDTH) + AW'(rd_col);
		wr_addr = AW'(RB'(head.item.pos_y)) * AW'(MAX_WIDTH) + AW'(CB'(head.item.pos_x));
		ram_addr = (state_q == S_FETCH) ? rd_addr : wr_addr;
	end

	lus_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(head.item.pixel_in),
		.rdata(ram_rdata)
	);

	always_comb begin
		pick = g00_s1;
		unique case (fy_q)
			2'd0: begin
				unique case (fx_q)
					2'd0: pick = g00_s1;
					2'd1: pick = avg(g00_s1, b_s2);
					2'd2: pick = b_s2;
					2'd3: pick = avg(b_s2, g01_s1);
				endcase
			end
			2'd1: begin
				unique case (fx_q)
					2'd0: pick = avg(g00_s1, h_s2);
					2'd1: pick = avg(b_s2, h_s2);
					2'd2: pick = avg(b_s2, j_s2);
					2'd3: pick = avg(b_s2, m_s2);
				endcase
			end
			2'd2: begin
				unique case (fx_q)
					2'd0: pick = h_s2;
					2'd1: pick = avg(h_s2, j_s2);
					2'd2: pick = j_s2;
					2'd3: pick = avg(j_s2, m_s2);
				endcase
			end
			2'd3: begin
				unique case (fx_q)
					2'd0: pick = avg(h_s2, g10_s1);
					2'd1: pick = avg(s_s2, h_s2);
					2'd2: pick = avg(j_s2, s_s2);
					2'd3: pick = avg(s_s2, m_s2);
				endcase
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			for (int i = 0; i < 35; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[35] <= ram_rdata;
		end
		if (state_q == S_IDLE && pop) begin
			r_q <= head.item.pos_y[9:2];
			c_q <= head.item.pos_x[9:2];
			fy_q <= head.item.pos_y[1:0];
			fx_q <= head.item.pos_x[1:0];
		end
		if (state_q == S_C1) begin
			for (int i = 0; i < 6; i++) begin
				hs_s1[i] <= 16'(tap6(px22(win_q[i*6]), px22(win_q[i*6+1]),
					px22(win_q[i*6+2]), px22(win_q[i*6+3]),
					px22(win_q[i*6+4]), px22(win_q[i*6+5])));
			end
			vs0_s1 <= 16'(tap6(px22(win_q[2]), px22(win_q[8]), px22(win_q[14]),
				px22(win_q[20]), px22(win_q[26]), px22(win_q[32])));
			vs1_s1 <= 16'(tap6(px22(win_q[3]), px22(win_q[9]), px22(win_q[15]),
				px22(win_q[21]), px22(win_q[27]), px22(win_q[33])));
			g00_s1 <= win_q[14];
			g01_s1 <= win_q[15];
			g10_s1 <= win_q[20];
		end
		if (state_q == S_C2) begin
			b_s2 <= sat((22'(hs_s1[2]) + 22'sd16) >>> 5);
			s_s2 <= sat((22'(hs_s1[3]) + 22'sd16) >>> 5);
			h_s2 <= sat((22'(vs0_s1) + 22'sd16) >>> 5);
			m_s2 <= sat((22'(vs1_s1) + 22'sd16) >>> 5);
			j_s2 <= sat((tap6(22'(hs_s1[0]), 22'(hs_s1[1]), 22'(hs_s1[2]),
				22'(hs_s1[3]), 22'(hs_s1[4]), 22'(hs_s1[5])) + 22'sd512) >>> 10);
		end
		if (state_q == S_IDLE && pop && head.kind == lus_pkg::K_OOR) begin
			result_q <= '{sample: 8'd0, out_of_range: 1'b1};
		end else if (state_q == S_C3) begin
			result_q <= '{sample: pick, out_of_range: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ri_q <= '0;
			ci_q <= '0;
			rd_pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rd_pend_q <= (state_q == S_FETCH);
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (head.kind == lus_pkg::K_READ) begin
							ri_q <= '0;
							ci_q <= '0;
							state_q <= S_FETCH;
						end else if (head.kind == lus_pkg::K_OOR) begin
							done_q <= 1'b1;
						end
					end
				end
				S_FETCH: begin
					if (ci_q == 3'd5) begin
						ci_q <= '0;
						ri_q <= ri_q + 3'd1;
						if (ri_q == 3'd5) begin
							state_q <= S_LAST;
						end
					end else begin
						ci_q <= ci_q + 3'd1;
					end
				end
				S_LAST: state_q <= S_C1;
				S_C1: state_q <= S_C2;
				S_C2: state_q <= S_C3;
				S_C3: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/luma_subpel_interpolator_unit.sv */
// Luma quarter-pel interpolator with its own reference frame store.
// An item is a transaction taken on a rising edge with start high and busy low.
// A write item (cmd 0) stores pixel_in at integer position (pos_x, pos_y) and
// gives no result; positions beyond the store are dropped. A read item (cmd 1)
// gives one result: the interpolated sample at a quarter-pel position, or
// out_of_range with sample 0 when the position lies beyond the frame.
// Each result is shown for one cycle with done high; the receiver takes it then.
// The frame size registers are written through cfg_valid/cfg_ready, index 0
// for the width and index 1 for the height; the user writes them only while
// the block is idle, not enforced by the block. Items pass a two-entry queue
// to the engine, so busy rises only when it fills. An item leaves the queue
// in the cycle after it is accepted when the engine is idle. A write is
// stored as it leaves the queue. A read inside the frame fetches a 6x6
// window of pixels through the single port of the frame store, one pixel a
// cycle, then filters it in three steps; done rises as the engine goes idle
// and no new item leaves the queue before then. An out-of-range read shows
// its result in the cycle after it leaves the queue. Reset empties the queue,
// sets the frame to 256 by 256 and leaves the frame store contents undefined.
`default_nettype none
module luma_subpel_interpolator_unit #(
	parameter int MAX_WIDTH = lus_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lus_pkg::MAX_HEIGHT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire lus_pkg::item_t item,
	output logic done,
	output lus_pkg::result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [lus_pkg::CFG_IW-1:0] cfg_index,
	input wire logic [lus_pkg::CFG_DW-1:0] cfg_data
);

	localparam int EW = $clog2(MAX_WIDTH+1);
	localparam int EH = $clog2(MAX_HEIGHT+1);
	localparam int DW = ((EW > EH) ? EW : EH) + lus_pkg::CFG_DW;

	logic [lus_pkg::CFG_DW-1:0] frame_width_q;
	logic [lus_pkg::CFG_DW-1:0] frame_height_q;
	logic [EW-1:0] eff_w;
	logic [EH-1:0] eff_h;
	logic q_full;
	logic push;
	lus_pkg::qent_t push_ent;
	logic pop;
	logic head_valid;
	lus_pkg::qent_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= lus_pkg::FRAME_DIM_RESET;
			frame_height_q <= lus_pkg::FRAME_DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == lus_pkg::CFG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data;
			end else if (cfg_index == lus_pkg::CFG_FRAME_HEIGHT) begin
				frame_height_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = EW'(1);
		end else if (DW'(frame_width_q) > DW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			eff_h = EH'(1);
		end else if (DW'(frame_height_q) > DW'(MAX_HEIGHT)) begin
			eff_h = EH'(MAX_HEIGHT);
		end else begin
			eff_h = EH'(frame_height_q);
		end
	end

	lus_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.start(start),
		.item(item),
		.eff_w(eff_w),
		.eff_h(eff_h),
		.q_full(q_full),
		.busy(busy),
		.push(push),
		.push_ent(push_ent)
	);

	lus_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ent(push_ent),
		.pop(pop),
		.full(q_full),
		.head_valid(head_valid),
		.head(head)
	);

	lus_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.eff_w(eff_w),
		.eff_h(eff_h),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.done(done),
		.result(result)
	);

endmodule
`default_nettype wire

/* rtl/lus_checker.sv */
`default_nettype none
module lus_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire lus_pkg::result_t result
);

	// An out-of-range result always carries a zero sample.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.out_of_range |-> result.sample == 8'd0)
		else $error("out-of-range result with nonzero sample");

	// A filtered result needs the whole window fetch, so done stays low while
	// its filter steps run.
	a_filter_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.out_of_range |-> !$past(done) && !$past(done, 2))
		else $error("filtered result too soon after previous result");

	// The queue fills only through an accepted transaction.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted transaction");

endmodule

bind luma_subpel_interpolator_unit lus_checker u_lus_checker (.*);
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	class subpel_predictor;
		logic [7:0] frame [65536];
		int eff_w;
		int eff_h;
		lus_pkg::result_t pending_samples[$];

		function new();
			foreach (frame[i]) frame[i] = 8'd0;
			eff_w = 256;
			eff_h = 256;
		endfunction

		function int clampi(int v, int lo, int hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void configure(logic [lus_pkg::CFG_IW-1:0] idx,
				logic [lus_pkg::CFG_DW-1:0] val);
			if (idx == lus_pkg::CFG_FRAME_WIDTH) eff_w = clampi(int'(val), 1, 256);
			else if (idx == lus_pkg::CFG_FRAME_HEIGHT) eff_h = clampi(int'(val), 1, 256);
		endfunction

		function int pix(int r, int c);
			r = clampi(r, 0, eff_h - 1);
			c = clampi(c, 0, eff_w - 1);
			return int'(frame[r * 256 + c]);
		endfunction

		function int tap(int k);
			case (k)
				0, 5: return 1;
				1, 4: return -5;
				default: return 20;
			endcase
		endfunction

		function int hsum(int r, int c);
			int s;
			s = 0;
			for (int k = 0; k < 6; k++) s += tap(k) * pix(r, c + k - 2);
			return s;
		endfunction

		function int clip_shift(int s, int sh);
			if (s < 0) return 0;
			s = s >>> sh;
			return s > 255 ? 255 : s;
		endfunction

		function int grid(int qy, int qx);
			int r;
			int c;
			int s;
			r = qy >>> 2;
			c = qx >>> 2;
			s = 0;
			if (!qy[1] && !qx[1]) return pix(r, c);
			if (!qy[1]) return clip_shift(hsum(r, c) + 16, 5);
			if (!qx[1]) begin
				for (int k = 0; k < 6; k++) s += tap(k) * pix(r + k - 2, c);
				return clip_shift(s + 16, 5);
			end
			for (int k = 0; k < 6; k++) s += tap(k) * hsum(clampi(r + k - 2, 0, eff_h - 1), c);
			return clip_shift(s + 512, 10);
		endfunction

		function int quarter(int qy, int qx);
			int cy;
			int cx;
			int hrow;
			int vcol;
			if (!qy[0] && !qx[0]) return grid(qy, qx);
			if (!qy[0]) return (grid(qy, qx - 1) + grid(qy, qx + 1) + 1) >>> 1;
			if (!qx[0]) return (grid(qy - 1, qx) + grid(qy + 1, qx) + 1) >>> 1;
			cy = (qy & ~3) + 2;
			cx = (qx & ~3) + 2;
			hrow = ((qy & 3) == 1) ? qy - 1 : qy + 1;
			vcol = ((qx & 3) == 1) ? qx - 1 : qx + 1;
			return (grid(hrow, cx) + grid(cy, vcol) + 1) >>> 1;
		endfunction

		function void note(lus_pkg::item_t it);
			lus_pkg::result_t r;
			int px;
			int py;
			px = int'(it.pos_x);
			py = int'(it.pos_y);
			if (it.cmd == lus_pkg::CMD_WRITE) begin
				if (px < 256 && py < 256) frame[py * 256 + px] = it.pixel_in;
				return;
			end
			if (px > 4 * eff_w - 4 || py > 4 * eff_h - 4) begin
				r.sample = 8'd0;
				r.out_of_range = 1'b1;
			end else begin
				r.sample = 8'(quarter(py, px));
				r.out_of_range = 1'b0;
			end
			pending_samples.push_back(r);
		endfunction

		function string check(lus_pkg::result_t got);
			lus_pkg::result_t exp_r;
			if (pending_samples.size() == 0) return "result with no read outstanding";
			exp_r = pending_samples.pop_front();
			if (got.sample !== exp_r.sample || got.out_of_range !== exp_r.out_of_range)
				return $sformatf("got sample %0d oor %0b, wanted sample %0d oor %0b",
					got.sample, got.out_of_range, exp_r.sample, exp_r.out_of_range);
			return "";
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	lus_pkg::item_t item = '0;
	logic done;
	lus_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lus_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [lus_pkg::CFG_DW-1:0] cfg_data = '0;

	subpel_predictor pred = new();
	int mismatches = 0;
	int quiet_cycles = 0;
	int cur_w = 256;
	int cur_h = 256;

	always #5 clk = ~clk;

	luma_subpel_interpolator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	task report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		string msg;
		if (arst_n && start && !busy) pred.note(item);
		if (arst_n && done) begin
			msg = pred.check(result);
			if (msg != "") report_mismatch(msg);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 3000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task send_item(logic c, int x, int y, int v);
		int gap;
		gap = $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= '{cmd: c, pos_x: 10'(x), pos_y: 10'(y), pixel_in: 8'(v)};
		do @(posedge clk); while (busy);
	endtask

	task wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pred.pending_samples.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task write_reg(logic [lus_pkg::CFG_IW-1:0] idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= lus_pkg::CFG_DW'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pred.configure(idx, lus_pkg::CFG_DW'(val));
	endtask

	task set_frame(int w, int h);
		wait_idle();
		write_reg(lus_pkg::CFG_FRAME_WIDTH, w);
		write_reg(lus_pkg::CFG_FRAME_HEIGHT, h);
		cur_w = pred.eff_w;
		cur_h = pred.eff_h;
	endtask

	task fill(int x0, int x1, int y0, int y1);
		for (int y = y0; y <= y1; y++)
			for (int x = x0; x <= x1; x++)
				send_item(lus_pkg::CMD_WRITE, x, y, $urandom_range(0, 255));
	endtask

	task random_traffic(int n, int wx, int wy);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 3)
				send_item(lus_pkg::CMD_WRITE, $urandom_range(0, wx - 1),
					$urandom_range(0, wy - 1), $urandom_range(0, 255));
			else if (pick == 3)
				send_item(lus_pkg::CMD_WRITE, $urandom_range(256, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 255));
			else if (pick < 6)
				send_item(lus_pkg::CMD_READ, $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 255));
			else
				send_item(lus_pkg::CMD_READ, $urandom_range(0, 4 * cur_w - 4),
					$urandom_range(0, 4 * cur_h - 4), $urandom_range(0, 255));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_item(lus_pkg::CMD_READ, 1023, 0, 255);
		send_item(lus_pkg::CMD_READ, 0, 1021, 0);
		send_item(lus_pkg::CMD_WRITE, 300, 5, 77);
		send_item(lus_pkg::CMD_WRITE, 5, 1023, 77);
		set_frame(16, 16);
		send_item(lus_pkg::CMD_WRITE, 0, 0, 255);
		send_item(lus_pkg::CMD_WRITE, 1, 0, 0);
		send_item(lus_pkg::CMD_WRITE, 0, 1, 0);
		send_item(lus_pkg::CMD_WRITE, 1, 1, 255);
		fill(2, 15, 0, 1);
		fill(0, 15, 2, 15);
		send_item(lus_pkg::CMD_READ, 0, 0, 0);
		send_item(lus_pkg::CMD_READ, 60, 60, 0);
		send_item(lus_pkg::CMD_READ, 2, 0, 0);
		send_item(lus_pkg::CMD_READ, 0, 2, 0);
		send_item(lus_pkg::CMD_READ, 2, 2, 0);
		send_item(lus_pkg::CMD_READ, 1, 1, 0);
		send_item(lus_pkg::CMD_READ, 3, 3, 0);
		send_item(lus_pkg::CMD_READ, 1, 3, 0);
		send_item(lus_pkg::CMD_READ, 3, 1, 0);
		send_item(lus_pkg::CMD_READ, 61, 0, 0);
		send_item(lus_pkg::CMD_READ, 0, 61, 0);
		random_traffic(60, 16, 16);
		set_frame(511, 1);
		fill(16, 255, 0, 0);
		random_traffic(30, 256, 1);
		set_frame(6, 6);
		random_traffic(20, 6, 6);
		set_frame(0, 5);
		random_traffic(15, 1, 5);
		set_frame(16, 9);
		random_traffic(20, 16, 16);
		wait_idle();
		if (mismatches == 0 && pred.pending_samples.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
